// ===== src/bec_pkg.sv =====
// Shared types and constants for the brake event counter and speedometer.
`timescale 1ns / 1ps

package bec_pkg;

    localparam int CNT_W    = 16;
    localparam int REV_W    = 12;
    localparam int SCALE_W  = 24;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd2;

    localparam logic [CNT_W-1:0]   LOCKOUT_RESET = 16'd3000;
    localparam logic [CNT_W-1:0]   WINDOW_RESET  = 16'd5000;
    localparam logic [SCALE_W-1:0] SCALE_RESET   = 24'd889435;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [REV_W-1:0] REV_MAX = {REV_W{1'b1}};

    typedef struct packed {
        logic [CNT_W-1:0]   lockout;
        logic [CNT_W-1:0]   window;
        logic [SCALE_W-1:0] scale;
    } cfg_t;

endpackage

// ===== src/brake_event_counter_speedometer.sv =====
// Top level of the brake event counter and speedometer.
//
// Each input item is one millisecond tick of five sampled pin levels, taken
// on in_valid with in_stall low. Every input item gives exactly one result
// item: four wrapping event counts, the last measured speed in tenths of
// km/h and a report flag, offered on out_valid until out_stall is low.
// An item is held in the input register and is then processed into the
// state and result registers, from which its result is offered on the
// outputs. One item per cycle is sustained while out_stall stays low; the
// limit is the combinational state update through the revolution-times-scale
// multiply.
// A stalled result holds the input register, which still takes one more
// item; in_stall rises only when both stages are full.
// Reset clears the counters and timers, sets the previous button and wheel
// levels to idle high and loads the default lockout, window and scale.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are meant for idle periods; an unknown index is ignored.
`timescale 1ns / 1ps

module brake_event_counter_speedometer
    import bec_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 right_foot_pin,
    input  logic                 left_foot_pin,
    input  logic                 foot_brake_touch,
    input  logic                 hand_brake_touch,
    input  logic                 wheel_sensor,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CNT_W-1:0]     right_foot_count,
    output logic [CNT_W-1:0]     left_foot_count,
    output logic [CNT_W-1:0]     foot_brake_count,
    output logic [CNT_W-1:0]     hand_brake_count,
    output logic [CNT_W-1:0]     speed_tenths,
    output logic                 report,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [4:0] pins_reg;
    logic       out_valid_reg;
    logic       report_reg, report_next;
    logic       advance;
    logic       accept;
    logic [3:0] hits;
    logic       speed_update;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lockout <= LOCKOUT_RESET;
            cfg_reg.window  <= WINDOW_RESET;
            cfg_reg.scale   <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOCKOUT: cfg_reg.lockout <= cfg_data[CNT_W-1:0];
                CFG_WINDOW:  cfg_reg.window  <= cfg_data[CNT_W-1:0];
                CFG_SCALE:   cfg_reg.scale   <= cfg_data[SCALE_W-1:0];
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            report_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                report_reg    <= report_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pins_reg <= {wheel_sensor, hand_brake_touch, foot_brake_touch,
                         left_foot_pin, right_foot_pin};
        end
    end

    bec_channel u_right (
        .clk(clk), .rst_n(rst_n), .step(advance), .touch_mode(1'b0),
        .level(pins_reg[0]), .cfg(cfg_reg), .count(right_foot_count), .hit(hits[0])
    );

    bec_channel u_left (
        .clk(clk), .rst_n(rst_n), .step(advance), .touch_mode(1'b0),
        .level(pins_reg[1]), .cfg(cfg_reg), .count(left_foot_count), .hit(hits[1])
    );

    bec_channel u_foot (
        .clk(clk), .rst_n(rst_n), .step(advance), .touch_mode(1'b1),
        .level(pins_reg[2]), .cfg(cfg_reg), .count(foot_brake_count), .hit(hits[2])
    );

    bec_channel u_hand (
        .clk(clk), .rst_n(rst_n), .step(advance), .touch_mode(1'b1),
        .level(pins_reg[3]), .cfg(cfg_reg), .count(hand_brake_count), .hit(hits[3])
    );

    bec_speed u_speed (
        .clk(clk), .rst_n(rst_n), .step(advance), .wheel(pins_reg[4]),
        .cfg(cfg_reg), .speed(speed_tenths), .update(speed_update)
    );

    assign report_next = (|hits) || speed_update;
    assign out_valid   = out_valid_reg;
    assign report      = report_reg;

    // An empty result stage never holds back the input side.
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled with empty result stage");

    // A processed item always lands as a valid result.
    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed item produced no result");

    // Any change of a count or of the speed is flagged in the same result.
    a_count_change_reported: assert property (@(posedge clk) disable iff (!rst_n)
        (!$stable(right_foot_count) || !$stable(left_foot_count) ||
         !$stable(foot_brake_count) || !$stable(hand_brake_count)) |-> report_reg)
        else $error("count changed without report");

    a_speed_change_reported: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(speed_tenths) |-> report_reg)
        else $error("speed changed without report");

    // Results change only when a new item moves into the result stage.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(right_foot_count) && $stable(report_reg))
        else $error("stalled result changed");

endmodule

// ===== src/bec_channel.sv =====
// One brake channel: edge or touch qualification, lockout timer and event counter.
`timescale 1ns / 1ps

module bec_channel
    import bec_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             touch_mode,
    input  logic             level,
    input  cfg_t             cfg,
    output logic [CNT_W-1:0] count,
    output logic             hit
);

    logic [CNT_W-1:0] since_reg, since_next, since_inc;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             aux_reg, aux_next;
    logic             held;
    logic             held_next;

    // The aux bit is the previous level for a button (idle high) and the
    // counted mark for a touch sensor (idle clear); it is stored so that
    // both idle states reset to zero.
    assign held = aux_reg ^ ~touch_mode;

    always_comb
    begin
        since_inc = (since_reg == CNT_MAX) ? CNT_MAX : since_reg + 1'b1;
        hit       = level && !held && (since_inc >= cfg.lockout);
        since_next = hit ? '0 : since_inc;
        count_next = hit ? count_reg + 1'b1 : count_reg;
        if (!touch_mode)
        begin
            held_next = level;
        end
        else if (hit)
        begin
            held_next = 1'b1;
        end
        else if (!level)
        begin
            held_next = 1'b0;
        end
        else
        begin
            held_next = held;
        end
        aux_next = held_next ^ ~touch_mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            since_reg <= '0;
            count_reg <= '0;
            aux_reg   <= 1'b0;
        end
        else if (step)
        begin
            since_reg <= since_next;
            count_reg <= count_next;
            aux_reg   <= aux_next;
        end
    end

    assign count = count_reg;

endmodule

// ===== src/bec_speed.sv =====
// Wheel revolution counter, measurement window and speed register.
`timescale 1ns / 1ps

module bec_speed
    import bec_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             wheel,
    input  cfg_t             cfg,
    output logic [CNT_W-1:0] speed,
    output logic             update
);

    localparam int PROD_W = REV_W + SCALE_W;
    localparam int FRAC_W = 16;

    logic             prev_wheel_reg;
    logic [REV_W-1:0] revs_reg, revs_next, revs_edge;
    logic [CNT_W-1:0] elapsed_reg, elapsed_next, elapsed_inc;
    logic [CNT_W-1:0] speed_reg, speed_next;
    logic [PROD_W:0]  product;
    logic [PROD_W-FRAC_W:0] rounded;

    always_comb
    begin
        elapsed_inc = (elapsed_reg == CNT_MAX) ? CNT_MAX : elapsed_reg + 1'b1;
        revs_edge   = (!wheel && prev_wheel_reg && revs_reg != REV_MAX) ?
                      revs_reg + 1'b1 : revs_reg;
        update      = elapsed_inc >= cfg.window;
        // Both operands are widened first so the full product is kept.
        product     = (PROD_W+1)'(revs_edge) * (PROD_W+1)'(cfg.scale) +
                      (PROD_W+1)'(32768);
        rounded     = product[PROD_W:FRAC_W];
        if (update)
        begin
            speed_next   = (rounded > (PROD_W-FRAC_W+1)'(CNT_MAX)) ?
                           CNT_MAX : rounded[CNT_W-1:0];
            revs_next    = '0;
            elapsed_next = '0;
        end
        else
        begin
            speed_next   = speed_reg;
            revs_next    = revs_edge;
            elapsed_next = elapsed_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_wheel_reg <= 1'b1;
            revs_reg       <= '0;
            elapsed_reg    <= '0;
            speed_reg      <= '0;
        end
        else if (step)
        begin
            prev_wheel_reg <= wheel;
            revs_reg       <= revs_next;
            elapsed_reg    <= elapsed_next;
            speed_reg      <= speed_next;
        end
    end

    assign speed = speed_reg;

endmodule

// ===== tb/tb_brake_event_counter_speedometer.sv =====
// Self-checking testbench for the brake event counter and speedometer.
`timescale 1ns / 1ps

module tb_brake_event_counter_speedometer;
    import bec_pkg::*;

    localparam int IDLE_PCT    = 27;
    localparam int STALL_LIMIT = 5000;
    localparam int MAX_REPORTS = 100;

    typedef enum int {CH_RIGHT, CH_LEFT, CH_FOOT, CH_HAND} channel_e;

    typedef struct packed {
        logic right_pin;
        logic left_pin;
        logic foot_touch;
        logic hand_touch;
        logic wheel;
    } pins_t;

    typedef struct packed {
        logic [CNT_W-1:0] right_cnt;
        logic [CNT_W-1:0] left_cnt;
        logic [CNT_W-1:0] foot_cnt;
        logic [CNT_W-1:0] hand_cnt;
        logic [CNT_W-1:0] speed;
        logic             report;
    } reading_t;

    // Pin patterns {right, left, foot, hand, wheel} for the edge and touch checks.
    localparam logic [4:0] EDGE_SCRIPT [10] = '{
        5'b00001, 5'b10001, 5'b11000, 5'b11101, 5'b11110,
        5'b01010, 5'b10110, 5'b01111, 5'b00100, 5'b11111
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 right_foot_pin = 1'b1;
    logic                 left_foot_pin = 1'b1;
    logic                 foot_brake_touch = 1'b0;
    logic                 hand_brake_touch = 1'b0;
    logic                 wheel_sensor = 1'b1;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [CNT_W-1:0]     right_foot_count;
    logic [CNT_W-1:0]     left_foot_count;
    logic [CNT_W-1:0]     foot_brake_count;
    logic [CNT_W-1:0]     hand_brake_count;
    logic [CNT_W-1:0]     speed_tenths;
    logic                 report;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_LOCKOUT;
    logic [CFG_W-1:0]     cfg_data = '0;

    brake_event_counter_speedometer dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .right_foot_pin   (right_foot_pin),
        .left_foot_pin    (left_foot_pin),
        .foot_brake_touch (foot_brake_touch),
        .hand_brake_touch (hand_brake_touch),
        .wheel_sensor     (wheel_sensor),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .right_foot_count (right_foot_count),
        .left_foot_count  (left_foot_count),
        .foot_brake_count (foot_brake_count),
        .hand_brake_count (hand_brake_count),
        .speed_tenths     (speed_tenths),
        .report           (report),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Copy of the block state kept by the testbench.
    cfg_t             tick_cfg;
    logic             prev_right;
    logic             prev_left;
    logic             prev_wheel;
    logic [1:0]       touch_marked;
    logic [CNT_W-1:0] ticks_since [4];
    logic [CNT_W-1:0] event_cnt [4];
    logic [REV_W-1:0] rev_cnt;
    logic [CNT_W-1:0] window_age;
    logic [CNT_W-1:0] speed_reg;
    reading_t         pending_readings [$];

    bit steady_flow = 1'b0;
    int failures = 0;
    int ticks_sent = 0;
    int readings_checked = 0;
    int reg_writes = 0;
    int idle_cycles = 0;

    function automatic void clear_tick_state();
        tick_cfg.lockout = LOCKOUT_RESET;
        tick_cfg.window  = WINDOW_RESET;
        tick_cfg.scale   = SCALE_RESET;
        prev_right = 1'b1;
        prev_left = 1'b1;
        prev_wheel = 1'b1;
        touch_marked = '0;
        for (int i = 0; i < 4; i++)
        begin
            ticks_since[i] = '0;
            event_cnt[i] = '0;
        end
        rev_cnt = '0;
        window_age = '0;
        speed_reg = '0;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic bit try_count(channel_e ch);
        if (ticks_since[ch] < tick_cfg.lockout)
            return 1'b0;
        event_cnt[ch] = event_cnt[ch] + 1'b1;
        ticks_since[ch] = '0;
        return 1'b1;
    endfunction

    // A touch counts once per high level; a level seen while locked out stays unmarked.
    function automatic bit touch_count(channel_e ch, int mark, logic level);
        bit counted;
        counted = 1'b0;
        if (level && !touch_marked[mark])
        begin
            if (try_count(ch))
            begin
                touch_marked[mark] = 1'b1;
                counted = 1'b1;
            end
        end
        else if (!level)
        begin
            touch_marked[mark] = 1'b0;
        end
        return counted;
    endfunction

    function automatic void advance_brake_state(pins_t p);
        reading_t         r;
        bit               any_event;
        longint unsigned  sp;
        any_event = 1'b0;
        for (int i = 0; i < 4; i++)
            ticks_since[i] = sat_inc(ticks_since[i]);
        window_age = sat_inc(window_age);

        if (p.right_pin && !prev_right && try_count(CH_RIGHT))
            any_event = 1'b1;
        prev_right = p.right_pin;
        if (p.left_pin && !prev_left && try_count(CH_LEFT))
            any_event = 1'b1;
        prev_left = p.left_pin;
        if (touch_count(CH_FOOT, 0, p.foot_touch))
            any_event = 1'b1;
        if (touch_count(CH_HAND, 1, p.hand_touch))
            any_event = 1'b1;

        if (!p.wheel && prev_wheel && rev_cnt != REV_MAX)
            rev_cnt = rev_cnt + 1'b1;
        prev_wheel = p.wheel;

        if (window_age >= tick_cfg.window)
        begin
            sp = (64'(rev_cnt) * 64'(tick_cfg.scale) + 64'd32768) >> 16;
            speed_reg = (sp > 64'(CNT_MAX)) ? CNT_MAX : sp[CNT_W-1:0];
            rev_cnt = '0;
            window_age = '0;
            any_event = 1'b1;
        end

        r.right_cnt = event_cnt[CH_RIGHT];
        r.left_cnt = event_cnt[CH_LEFT];
        r.foot_cnt = event_cnt[CH_FOOT];
        r.hand_cnt = event_cnt[CH_HAND];
        r.speed = speed_reg;
        r.report = any_event;
        pending_readings.push_back(r);
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    // in_valid is left high so back-to-back items need no extra transition.
    task automatic send_tick(input pins_t p);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        right_foot_pin = p.right_pin;
        left_foot_pin = p.left_pin;
        foot_brake_touch = p.foot_touch;
        hand_brake_touch = p.hand_touch;
        wheel_sensor = p.wheel;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_brake_state(p);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic drain_readings();
        in_valid = 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        drain_readings();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_LOCKOUT: tick_cfg.lockout = data[CNT_W-1:0];
            CFG_WINDOW:  tick_cfg.window = data[CNT_W-1:0];
            CFG_SCALE:   tick_cfg.scale = data[SCALE_W-1:0];
            default:     ;
        endcase
        reg_writes++;
    endtask

    // Unused upper bits of the 16-bit registers carry random junk.
    task automatic configure(input logic [CNT_W-1:0] lockout, input logic [CNT_W-1:0] window,
                             input logic [SCALE_W-1:0] scale);
        logic [CFG_W-1:0] junk;
        junk = CFG_W'($urandom);
        write_reg(CFG_LOCKOUT, {junk[CFG_W-1:CNT_W], lockout});
        junk = CFG_W'($urandom);
        write_reg(CFG_WINDOW, {junk[CFG_W-1:CNT_W], window});
        write_reg(CFG_SCALE, scale);
    endtask

    function automatic pins_t wander(pins_t cur);
        pins_t nxt;
        nxt = cur;
        if ($urandom_range(99) < 10)
            return pins_t'(5'($urandom_range(31)));
        if ($urandom_range(99) < 30) nxt.right_pin = ~nxt.right_pin;
        if ($urandom_range(99) < 30) nxt.left_pin = ~nxt.left_pin;
        if ($urandom_range(99) < 30) nxt.foot_touch = ~nxt.foot_touch;
        if ($urandom_range(99) < 30) nxt.hand_touch = ~nxt.hand_touch;
        if ($urandom_range(99) < 50) nxt.wheel = ~nxt.wheel;
        return nxt;
    endfunction

    // Default lockout holds every count off, so only idle readings come back.
    task automatic test_reset_defaults();
        for (int n = 0; n < 4; n++)
            send_tick(n[0] ? pins_t'(5'b11110) : pins_t'(5'b00001));
    endtask

    task automatic test_edges_and_touches();
        configure(16'd0, 16'd3, SCALE_RESET);
        foreach (EDGE_SCRIPT[i])
            send_tick(pins_t'(EDGE_SCRIPT[i]));
        // A short lockout lets a held touch count late; window of one updates every tick.
        configure(16'd2, 16'd1, {SCALE_W{1'b1}});
        foreach (EDGE_SCRIPT[i])
            send_tick(pins_t'(EDGE_SCRIPT[i]));
    endtask

    task automatic test_random_mix();
        pins_t            cur;
        logic [CNT_W-1:0] lockout;
        logic [CNT_W-1:0] window;
        logic [SCALE_W-1:0] scale;
        for (int ph = 0; ph < 6; ph++)
        begin
            lockout = (ph == 0) ? 16'd0 : (ph == 5) ? CNT_MAX : 16'($urandom_range(1, 12));
            window = (ph == 1) ? 16'd1 : 16'($urandom_range(2, 40));
            scale = SCALE_W'($urandom);
            if (ph == 2)
                scale = '0;
            else if (ph == 3)
                scale = {SCALE_W{1'b1}};
            configure(lockout, window, scale);
            steady_flow = (ph == 4);
            cur = pins_t'(5'($urandom_range(31)));
            for (int n = 0; n < 70; n++)
            begin
                if (ph == 2 && n == 35)
                    drain_readings();
                cur = wander(cur);
                send_tick(cur);
            end
            steady_flow = 1'b0;
        end
    endtask

    // Lockout and window at their maximum: nothing counts and the speed never
    // updates, however busy the pins are.
    task automatic test_max_settings();
        pins_t p;
        configure(CNT_MAX, CNT_MAX, {SCALE_W{1'b1}});
        for (int n = 0; n < 24; n++)
        begin
            p.right_pin = n[0];
            p.left_pin = ~n[0];
            p.foot_touch = 1'b1;
            p.hand_touch = (n % 3) != 0;
            p.wheel = n[0];
            send_tick(p);
        end
    endtask

    // With no lockout every channel counts every other tick, first back to back.
    task automatic test_rapid_counts();
        pins_t p;
        logic [SCALE_W-1:0] scale;
        scale = SCALE_W'($urandom);
        configure(16'd0, 16'd1, scale);
        for (int n = 0; n < 32; n++)
        begin
            steady_flow = (n < 16);
            p.right_pin = n[0];
            p.left_pin = ~n[0];
            p.foot_touch = n[0];
            p.hand_touch = ~n[0];
            p.wheel = n[1];
            send_tick(p);
        end
        steady_flow = 1'b0;
    endtask

    always @(negedge clk)
        out_stall = !steady_flow && ($urandom_range(99) < IDLE_PCT);

    function automatic void note_failure(string what, logic [CNT_W-1:0] want,
                                         logic [CNT_W-1:0] got);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        else if (failures == MAX_REPORTS + 1)
            $display("%0t: further mismatches not shown", $time);
    endfunction

    function automatic void check_field(string what, logic [CNT_W-1:0] want,
                                        logic [CNT_W-1:0] got);
        if (got !== want)
            note_failure(what, want, got);
    endfunction

    always @(posedge clk)
    begin : check_readings
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            readings_checked++;
            if (pending_readings.size() == 0)
            begin
                note_failure("reading with nothing pending, report", 16'd0, 16'(report));
            end
            else
            begin
                want = pending_readings.pop_front();
                check_field("right_foot_count", want.right_cnt, right_foot_count);
                check_field("left_foot_count", want.left_cnt, left_foot_count);
                check_field("foot_brake_count", want.foot_cnt, foot_brake_count);
                check_field("hand_brake_count", want.hand_cnt, hand_brake_count);
                check_field("speed_tenths", want.speed, speed_tenths);
                check_field("report", 16'(want.report), 16'(report));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        clear_tick_state();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_edges_and_touches();
        test_random_mix();
        test_max_settings();
        test_rapid_counts();

        drain_readings();
        repeat (8) @(posedge clk);
        $display("%0d ticks sent, %0d readings checked, %0d register writes",
                 ticks_sent, readings_checked, reg_writes);
        $display("Covered button edges, touch marks, lockout from zero to its maximum, ",
                 "one-tick and long windows, zero and full scale, and back-to-back counts.");
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
